// ===== rtl/gbc_pkg.sv =====
`default_nettype none

package gbc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int SAMPLE_BITS  = 16;
	localparam int WEIGHT_BITS  = 15;
	localparam int PROD_BITS    = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam int SUM_BITS     = 34;
	localparam int FW_BITS      = 11;
	localparam int FH_BITS      = 13;
	localparam int CFG_BITS     = 13;
	localparam int ROW_OUT_BITS = 12;
	localparam int COL_OUT_BITS = 10;

	localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_BITS-1:0] FH_RESET = 13'd1024;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_DRAIN  = 1'b1;

	localparam logic [1:0] OP_FILL  = 2'd0;
	localparam logic [1:0] OP_SHIFT = 2'd1;
	localparam logic [1:0] OP_EDGE  = 2'd2;

	// window row source: a line store slot, or the incoming sample
	localparam logic [2:0] SRC_SAMPLE = 3'd4;

	typedef logic signed [SAMPLE_BITS-1:0] samp_t;
	typedef samp_t [4:0] colv_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;

	typedef struct packed {
		logic adv;
		logic fill;
		logic shift;
	} cell_ctrl_t;

	// gaussian weights in q0.16, symmetric in both axes
	function automatic logic [WEIGHT_BITS-1:0] kern_w(input int c, input int k);
		int dc;
		int dk;
		logic [WEIGHT_BITS-1:0] w;
		dc = (c > 2) ? 4 - c : c;
		dk = (k > 2) ? 4 - k : k;
		unique case (dc * 3 + dk)
			0: w = 15'd247;
			1: w = 15'd984;
			2: w = 15'd1559;
			3: w = 15'd984;
			4: w = 15'd3926;
			5: w = 15'd6220;
			6: w = 15'd1559;
			7: w = 15'd6220;
			8: w = 15'd9853;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gaussian_blur_5x5_clamped.sv =====
// path: s1 (store read), window, products, column sums, total, output register
// throughput: one request per cycle unless the output stalls; a sample that ends a row
//   holds the input for its edge columns; each drain row opens with priming store reads
// the rate is set by the single read port of each line store bank and the window shift
// reset: arst_n clears control, counters, window and config; line store has no clear
`default_nettype none

module gaussian_blur_5x5_clamped import gbc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      write_enable,
	input  logic                      reg_index,
	input  logic [CFG_BITS-1:0]       write_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic signed [15:0]        height,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [15:0]        blurred_height,
	output logic [ROW_OUT_BITS-1:0]   out_row,
	output logic [COL_OUT_BITS-1:0]   out_col,
	output logic                      last_of_run,
	output logic                      frame_end
);

	localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int UW_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int UH_BITS  = $clog2(MAX_HEIGHT + 1);

	typedef struct packed {
		logic                    valid;
		logic                    last;
		logic                    fe;
		logic [ROW_OUT_BITS-1:0] row;
		logic [COL_OUT_BITS-1:0] col;
	} meta_t;

	typedef struct packed {
		logic             valid;
		logic [1:0]       kind;
		logic [4:0][2:0]  src;
		samp_t            sample;
		meta_t            meta;
	} op_t;

	// configuration registers
	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;
	logic [UW_BITS-1:0] used_w;
	logic [UH_BITS-1:0] used_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= write_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= write_data[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// clamp the programmed geometry to [1, max]
	always_comb begin
		if (frame_width_q == '0) begin
			used_w = UW_BITS'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			used_w = UW_BITS'(MAX_WIDTH);
		end else begin
			used_w = UW_BITS'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			used_h = UH_BITS'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			used_h = UH_BITS'(MAX_HEIGHT);
		end else begin
			used_h = UH_BITS'(frame_height_q);
		end
	end

	// frame position and drain sequencing
	logic [ROW_BITS-1:0]     in_row_q;
	logic [COL_BITS-1:0]     in_col_q;
	logic [COL_BITS-1:0]     drain_col_q;
	logic                    drain_hi_q;
	logic                    drain_pending_q;
	logic [1:0]              prime_cnt_q;
	logic [1:0]              edge_cnt_q;
	logic [COL_BITS-1:0]     edge_x_q;
	logic                    edge_y2_q;
	logic [ROW_OUT_BITS-1:0] edge_row_q;

	logic adv;
	logic out_valid_q;
	logic issue_edge, issue_prime, acc, take_drain, take_samp;

	// whole pipeline moves together unless the output register is held
	assign adv = !out_valid_q || !out_stall;

	assign issue_edge  = (edge_cnt_q != 2'd0);
	assign issue_prime = !issue_edge && (prime_cnt_q != 2'd0);
	assign in_stall    = !adv || (edge_cnt_q != 2'd0) || (prime_cnt_q != 2'd0);
	assign acc         = in_valid && !in_stall;
	// drains with nothing pending and samples during a drain are taken and dropped
	assign take_drain  = acc && (func == FUNC_DRAIN) && drain_pending_q;
	assign take_samp   = acc && (func == FUNC_SAMPLE) && !drain_pending_q;

	logic           two_rows, last_drow, col_end, drain_fe, endrow, last_row, y2;
	logic [4:0][2:0] drain_src, samp_src;
	logic [COL_BITS-1:0] rd_col;
	op_t            op_nxt;

	always_comb begin
		int w_i, h_i, y_i, x_i, r_i, dc_i, t, e_i;
		w_i = int'(used_w);
		h_i = int'(used_h);
		y_i = int'(in_row_q);
		x_i = int'(in_col_q);
		dc_i = int'(drain_col_q);

		// drained rows: the last two of the frame, or one for a single-row frame
		two_rows  = (h_i >= 2);
		r_i       = h_i - (two_rows ? 2 : 1) + (drain_hi_q ? 1 : 0);
		last_drow = drain_hi_q || !two_rows;
		col_end   = (dc_i >= w_i - 1);
		drain_fe  = last_drow && col_end;
		for (int i = 0; i < 5; i++) begin
			t = r_i + i - 2;
			if (t < 0) t = 0;
			if (t > h_i - 1) t = h_i - 1;
			drain_src[i] = {1'b0, 2'(t)};
		end

		// sample column: rows y-4..y clamped at the top, row y from the input
		for (int k = 0; k < 5; k++) begin
			t = y_i - 4 + k;
			if (t < 0) t = 0;
			samp_src[k] = (t == y_i) ? SRC_SAMPLE : {1'b0, 2'(t)};
		end
		endrow   = (x_i + 1 >= w_i);
		last_row = (y_i + 1 >= h_i);
		y2       = (y_i >= 2);

		op_nxt = '0;
		rd_col = in_col_q;
		e_i    = (edge_cnt_q == 2'd2) ? 1 : 2;

		if (issue_edge) begin
			// replicate the right edge column
			op_nxt.valid     = 1'b1;
			op_nxt.kind      = OP_EDGE;
			op_nxt.meta.valid = edge_y2_q && (int'(edge_x_q) >= e_i);
			op_nxt.meta.last = (e_i == 2) || !(edge_y2_q && (int'(edge_x_q) >= 2));
			op_nxt.meta.row  = edge_row_q;
			op_nxt.meta.col  = COL_OUT_BITS'(int'(edge_x_q) - e_i);
		end else if (issue_prime) begin
			// preload columns 0 and 1 before the first drain pixel of a row
			op_nxt.valid = 1'b1;
			op_nxt.kind  = (prime_cnt_q == 2'd2) ? OP_FILL : OP_SHIFT;
			op_nxt.src   = drain_src;
			rd_col       = (prime_cnt_q == 2'd2 || w_i < 2) ? '0 : COL_BITS'(1);
		end else if (take_drain) begin
			op_nxt.valid      = 1'b1;
			op_nxt.kind       = OP_SHIFT;
			op_nxt.src        = drain_src;
			op_nxt.meta.valid = 1'b1;
			op_nxt.meta.last  = 1'b1;
			op_nxt.meta.fe    = drain_fe;
			op_nxt.meta.row   = ROW_OUT_BITS'(r_i);
			op_nxt.meta.col   = drain_fe ? COL_OUT_BITS'(w_i - 1) : COL_OUT_BITS'(dc_i);
			rd_col = (dc_i + 2 > w_i - 1) ? COL_BITS'(w_i - 1) : COL_BITS'(dc_i + 2);
		end else if (take_samp) begin
			op_nxt.valid      = 1'b1;
			op_nxt.kind       = (x_i == 0) ? OP_FILL : OP_SHIFT;
			op_nxt.src        = samp_src;
			op_nxt.sample     = height;
			op_nxt.meta.valid = y2 && (x_i >= 2);
			op_nxt.meta.last  = !(endrow && y2 && (x_i >= 1));
			op_nxt.meta.row   = ROW_OUT_BITS'(y_i - 2);
			op_nxt.meta.col   = COL_OUT_BITS'(x_i - 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q        <= '0;
			in_col_q        <= '0;
			drain_col_q     <= '0;
			drain_hi_q      <= 1'b0;
			drain_pending_q <= 1'b0;
			prime_cnt_q     <= '0;
			edge_cnt_q      <= '0;
			edge_x_q        <= '0;
			edge_y2_q       <= 1'b0;
			edge_row_q      <= '0;
		end else if (adv) begin
			if (issue_edge) begin
				edge_cnt_q <= edge_cnt_q - 2'd1;
			end else if (issue_prime) begin
				prime_cnt_q <= prime_cnt_q - 2'd1;
			end else if (take_drain) begin
				if (drain_fe) begin
					// frame done, back to the top left
					drain_pending_q <= 1'b0;
					drain_hi_q      <= 1'b0;
					drain_col_q     <= '0;
					in_row_q        <= '0;
					in_col_q        <= '0;
				end else if (col_end) begin
					drain_hi_q  <= 1'b1;
					drain_col_q <= '0;
					prime_cnt_q <= 2'd2;
				end else begin
					drain_col_q <= drain_col_q + 1'b1;
				end
			end else if (take_samp) begin
				if (endrow) begin
					edge_cnt_q <= 2'd2;
					edge_x_q   <= in_col_q;
					edge_y2_q  <= y2;
					edge_row_q <= ROW_OUT_BITS'(int'(in_row_q) - 2);
					in_col_q   <= '0;
					if (last_row) begin
						drain_pending_q <= 1'b1;
						drain_col_q     <= '0;
						drain_hi_q      <= 1'b0;
						prime_cnt_q     <= 2'd2;
					end else begin
						in_row_q <= in_row_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

	// line store: one bank per row slot (row mod 4), all read at the same column
	samp_t bank_rd [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		gbc_line_bank #(
			.DEPTH(MAX_WIDTH)
		) u_bank (
			.clk   (clk),
			.we    (take_samp && (2'(in_row_q) == 2'(b))),
			.waddr (in_col_q),
			.wdata (height),
			.re    (adv),
			.raddr (rd_col),
			.rdata (bank_rd[b])
		);
	end

	// s1: request in flight, store read data now valid
	op_t op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else if (adv) begin
			op_s1 <= op_nxt;
		end
	end

	colv_t      newcol;
	colv_t      feed;
	colv_t      cell_data [5];
	sum_t       cell_sum  [5];
	cell_ctrl_t cctrl;

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			newcol[k] = (op_s1.src[k] == SRC_SAMPLE) ? op_s1.sample : bank_rd[op_s1.src[k][1:0]];
		end
		// edge shifts feed the newest column back into itself
		feed = (op_s1.kind == OP_EDGE) ? cell_data[4] : newcol;
		cctrl.adv   = adv;
		cctrl.fill  = op_s1.valid && (op_s1.kind == OP_FILL);
		cctrl.shift = op_s1.valid && (op_s1.kind != OP_FILL);
	end

	// window: five column cells, oldest at index 0
	for (genvar c = 0; c < 5; c++) begin : g_cell
		gbc_cell #(
			.COL(c)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cctrl),
			.nbr_in  ((c < 4) ? cell_data[(c < 4) ? c + 1 : 4] : feed),
			.fill_in (newcol),
			.data    (cell_data[c]),
			.col_sum (cell_sum[c])
		);
	end

	// result tags follow the window through products, column sums and the total
	// (a tag is only marked valid on a valid op, so it passes through as is)
	meta_t meta_s2, meta_s3, meta_s4, meta_s5;
	sum_t  total_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
		end else if (adv) begin
			meta_s2       <= op_s1.meta;
			meta_s3       <= meta_s2;
			meta_s4       <= meta_s3;
			meta_s5       <= meta_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_s5 <= cell_sum[0] + cell_sum[1] + cell_sum[2] + cell_sum[3] + cell_sum[4];
		end
	end

	// round half up, then saturate to 16 bits
	logic signed [SUM_BITS-1:0]  rnd_sum;
	logic signed [SUM_BITS-17:0] rnd_q;
	logic signed [15:0]          sat_val;

	always_comb begin
		rnd_sum = total_s5 + SUM_BITS'(32768);
		rnd_q   = rnd_sum[SUM_BITS-1:16];
		if (rnd_q > (SUM_BITS-16)'(32767)) begin
			sat_val = 16'sh7fff;
		end else if (rnd_q < -(SUM_BITS-16)'(32768)) begin
			sat_val = 16'sh8000;
		end else begin
			sat_val = rnd_q[15:0];
		end
	end

	// output register
	logic signed [15:0]      blur_q;
	logic [ROW_OUT_BITS-1:0] row_q;
	logic [COL_OUT_BITS-1:0] col_q;
	logic                    last_q, fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= meta_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blur_q <= sat_val;
			row_q  <= meta_s5.row;
			col_q  <= meta_s5.col;
			last_q <= meta_s5.last;
			fe_q   <= meta_s5.fe;
		end
	end

	assign out_valid      = out_valid_q;
	assign blurred_height = blur_q;
	assign out_row        = row_q;
	assign out_col        = col_q;
	assign last_of_run    = last_q;
	assign frame_end      = fe_q;

endmodule

`default_nettype wire

// ===== rtl/gbc_line_bank.sv =====
`default_nettype none

module gbc_line_bank import gbc_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  samp_t                wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output samp_t                rdata
);

	samp_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gbc_cell.sv =====
`default_nettype none

module gbc_cell import gbc_pkg::*; #(
	parameter int COL = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  colv_t      nbr_in,
	input  colv_t      fill_in,
	output colv_t      data,
	output sum_t       col_sum
);

	colv_t                        data_q;
	logic signed [PROD_BITS-1:0]  prod_s3 [5];
	sum_t                         sum_s4;

	// one window column, shifted toward the older neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctrl.adv && ctrl.fill) begin
			data_q <= fill_in;
		end else if (ctrl.adv && ctrl.shift) begin
			data_q <= nbr_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int k = 0; k < 5; k++) begin
				prod_s3[k] <= $signed(data_q[k]) * $signed({1'b0, kern_w(COL, k)});
			end
			sum_s4 <= SUM_BITS'(prod_s3[0]) + SUM_BITS'(prod_s3[1]) + SUM_BITS'(prod_s3[2])
				+ SUM_BITS'(prod_s3[3]) + SUM_BITS'(prod_s3[4]);
		end
	end

	assign data    = data_q;
	assign col_sum = sum_s4;

endmodule

`default_nettype wire

// ===== rtl/gbc_checker.sv =====
`default_nettype none

module gbc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] blurred_height,
	input logic [11:0]        out_row,
	input logic [9:0]         out_col,
	input logic               last_of_run,
	input logic               frame_end
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(blurred_height) && $stable(out_row)
			&& $stable(out_col) && $stable(last_of_run) && $stable(frame_end))
		else $error("held result changed");

	// the frame's final pixel always closes its request
	a_fe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last_of_run)
		else $error("frame end without last of run");

	// a blocked output freezes the pipeline, so no request may enter
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request accepted while output blocked");

endmodule

bind gaussian_blur_5x5_clamped gbc_checker u_gbc_checker (.*);

`default_nettype wire

// ===== bench/tb_gaussian_blur_5x5_clamped.sv =====
`default_nettype none

module tb_gaussian_blur_5x5_clamped;
	import gbc_pkg::*;

	localparam int LIMIT     = 1000000;
	localparam int SETTLE    = 20;   // margin beyond the result latency
	localparam int STORE_W   = 1024;
	localparam int STORE_H   = 4096;

	typedef struct {
		logic               f;
		logic signed [15:0] h;
	} request_t;

	typedef struct {
		logic signed [15:0] val;
		logic [11:0]        row;
		logic [9:0]         col;
		logic               last;
		logic               fend;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic write_enable = 1'b0;
	logic reg_index = REG_FRAME_WIDTH;
	logic [CFG_BITS-1:0] write_data = '0;
	logic in_valid = 1'b0;
	logic func = FUNC_SAMPLE;
	logic signed [15:0] height = '0;
	logic out_stall = 1'b0;
	wire in_stall;
	wire out_valid;
	wire signed [15:0] blurred_height;
	wire [11:0] out_row;
	wire [9:0] out_col;
	wire last_of_run;
	wire frame_end;

	gaussian_blur_5x5_clamped uut (
		.clk(clk), .arst_n(arst_n),
		.write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .height(height),
		.out_valid(out_valid), .out_stall(out_stall), .blurred_height(blurred_height),
		.out_row(out_row), .out_col(out_col), .last_of_run(last_of_run),
		.frame_end(frame_end)
	);

	always #5 clk = ~clk;

	// stimulus waiting for the driver, and blurred pixels waiting for the monitor
	request_t pending_requests[$];
	pixel_t   expected_pixels[$];
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	int       errors = 0;
	int       cycles = 0;

	// predictor state: line store, window, raster position and drain progress
	logic signed [15:0] line_store[4][STORE_W];
	logic signed [15:0] win[25];
	int       cur_row, cur_col, drain_idx;
	bit       draining;
	int       cfg_width = 1024;
	int       cfg_height = 1024;

	function automatic int used_width();
		if (cfg_width < 1) return 1;
		return (cfg_width > STORE_W) ? STORE_W : cfg_width;
	endfunction

	function automatic int used_height();
		if (cfg_height < 1) return 1;
		return (cfg_height > STORE_H) ? STORE_H : cfg_height;
	endfunction

	function automatic int gauss_weight(int i, int j);
		int di;
		int dj;
		int k;
		di = (i > 2) ? 4 - i : i;
		dj = (j > 2) ? 4 - j : j;
		k = di * 3 + dj;
		case (k)
			0: return 247;
			1, 3: return 984;
			2, 6: return 1559;
			4: return 3926;
			5, 7: return 6220;
			default: return 9853;
		endcase
	endfunction

	// round half up, then saturate to 16 bits
	function automatic logic signed [15:0] round_sat(longint acc);
		longint q;
		q = (acc + 32768) >>> 16;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	// window slot 5*c + k holds column c (oldest first), row offset k
	function automatic logic signed [15:0] blur_window();
		longint acc;
		acc = 0;
		for (int c = 0; c < 5; c++)
			for (int k = 0; k < 5; k++)
				acc += longint'(win[c*5+k]) * gauss_weight(k, c);
		return round_sat(acc);
	endfunction

	function automatic void shift_window(logic signed [15:0] colv[5]);
		for (int k = 0; k < 20; k++)
			win[k] = win[k+5];
		for (int k = 0; k < 5; k++)
			win[20+k] = colv[k];
	endfunction

	function automatic pixel_t make_pixel(logic signed [15:0] v, int r, int c, bit fe);
		pixel_t p;
		p.val = v;
		p.row = r[11:0];
		p.col = c[9:0];
		p.last = 1'b0;
		p.fend = fe;
		return p;
	endfunction

	// advance the predictor by one accepted request and queue its pixels
	function automatic void predict_blur(logic f, logic signed [15:0] h);
		int w_u, h_u, nrows, cnt, d, r, c, rr, cc, x, y, n;
		bit fe;
		longint acc;
		logic signed [15:0] colv[5];
		logic signed [15:0] edge_col[5];
		pixel_t outs[3];
		w_u = used_width();
		h_u = used_height();
		n = 0;
		if (f == FUNC_DRAIN) begin
			if (!draining)
				return;
			nrows = (h_u >= 2) ? 2 : 1;
			cnt = nrows * w_u;
			d = drain_idx;
			fe = 0;
			if (d >= cnt - 1) begin
				d = cnt - 1;
				fe = 1;
			end
			r = h_u - nrows + d / w_u;
			c = d % w_u;
			acc = 0;
			for (int i = -2; i <= 2; i++) begin
				rr = r + i;
				if (rr < 0) rr = 0;
				if (rr > h_u - 1) rr = h_u - 1;
				for (int j = -2; j <= 2; j++) begin
					cc = c + j;
					if (cc < 0) cc = 0;
					if (cc > w_u - 1) cc = w_u - 1;
					acc += longint'(line_store[rr % 4][cc]) * gauss_weight(i + 2, j + 2);
				end
			end
			outs[n++] = make_pixel(round_sat(acc), r, c, fe);
			if (fe) begin
				draining = 0;
				drain_idx = 0;
				cur_row = 0;
				cur_col = 0;
			end else begin
				drain_idx = d + 1;
			end
		end else begin
			// samples are dropped while the last rows are being drained
			if (draining)
				return;
			y = cur_row;
			x = (cur_col >= STORE_W) ? STORE_W - 1 : cur_col;
			for (int k = 0; k < 5; k++) begin
				rr = y - 4 + k;
				if (rr < 0) rr = 0;
				colv[k] = (rr == y) ? h : line_store[rr % 4][x];
			end
			line_store[y % 4][x] = h;
			if (x == 0) begin
				for (int cl = 0; cl < 5; cl++)
					for (int k = 0; k < 5; k++)
						win[cl*5+k] = colv[k];
			end else begin
				shift_window(colv);
			end
			if (y >= 2 && x >= 2)
				outs[n++] = make_pixel(blur_window(), y - 2, x - 2, 0);
			if (x + 1 >= w_u) begin
				// row end: replicate the edge column for the owed columns
				for (int k = 0; k < 5; k++)
					edge_col[k] = win[20+k];
				for (int e = 1; e <= 2; e++) begin
					shift_window(edge_col);
					if (y >= 2 && x >= e)
						outs[n++] = make_pixel(blur_window(), y - 2, x - e, 0);
				end
				cur_col = 0;
				if (y + 1 >= h_u) begin
					draining = 1;
					drain_idx = 0;
				end else begin
					cur_row = y + 1;
				end
			end else begin
				cur_col = x + 1;
			end
		end
		if (n > 0)
			outs[n-1].last = 1'b1;
		for (int k = 0; k < n; k++)
			expected_pixels.push_back(outs[k]);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
	endtask

	// driver: predicts each request as it is accepted, then offers the next one
	always @(posedge clk) begin
		request_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_blur(func, height);
			if (!in_valid || !in_stall) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_requests.pop_front();
					in_valid <= 1'b1;
					func <= nxt.f;
					height <= nxt.h;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result against the oldest expectation
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("unexpected result at row %0d col %0d", out_row, out_col);
				end else begin
					want = expected_pixels.pop_front();
					if (blurred_height !== want.val)
						report_mismatch("blurred_height", int'(blurred_height),
							int'(want.val));
					if (out_row !== want.row)
						report_mismatch("out_row", int'(out_row), int'(want.row));
					if (out_col !== want.col)
						report_mismatch("out_col", int'(out_col), int'(want.col));
					if (last_of_run !== want.last)
						report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
					if (frame_end !== want.fend)
						report_mismatch("frame_end", int'(frame_end), int'(want.fend));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sender holds off until every queued request went in and all pixels came out
	task automatic wait_idle();
		while (pending_requests.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		@(posedge clk);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= value[CFG_BITS-1:0];
		@(posedge clk);
		write_enable <= 1'b0;
		if (idx == REG_FRAME_WIDTH)
			cfg_width = value & 11'h7ff;
		else
			cfg_height = value & 13'h1fff;
	endtask

	function automatic logic signed [15:0] rand_height();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic void queue_request(logic f, logic signed [15:0] h);
		request_t q;
		q.f = f;
		q.h = h;
		pending_requests.push_back(q);
	endfunction

	// one whole frame; noisy frames add ignored drains and dropped samples
	task automatic send_frame(int w_reg, int h_reg, bit noisy);
		int cnt;
		wait_idle();
		write_reg(REG_FRAME_WIDTH, w_reg);
		write_reg(REG_FRAME_HEIGHT, h_reg);
		cnt = used_width() * used_height();
		if (noisy)
			queue_request(FUNC_DRAIN, rand_height());
		for (int i = 0; i < cnt; i++) begin
			queue_request(FUNC_SAMPLE, rand_height());
			if (noisy && $urandom_range(9) == 0)
				queue_request(FUNC_DRAIN, 16'($urandom()));
		end
		cnt = ((used_height() >= 2) ? 2 : 1) * used_width();
		for (int i = 0; i < cnt; i++) begin
			if (noisy && $urandom_range(5) == 0)
				queue_request(FUNC_SAMPLE, rand_height());
			queue_request(FUNC_DRAIN, 16'($urandom()));
		end
	endtask

	initial begin
		for (int s = 0; s < 4; s++)
			for (int c = 0; c < STORE_W; c++)
				line_store[s][c] = '0;
		for (int k = 0; k < 25; k++)
			win[k] = '0;
		cur_row = 0;
		cur_col = 0;
		drain_idx = 0;
		draining = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme heights, noise, tiny frames, zero sizes, single rows
		send_frame(3, 3, 1);
		send_frame(1, 1, 1);
		send_frame(0, 0, 0);
		send_frame(2, 5, 1);
		send_frame(6, 1, 0);

		// random frames under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 53; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 53; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			for (int fr = 0; fr < 2; fr++)
				send_frame($urandom_range(1, 6), $urandom_range(1, 5),
					1'($urandom_range(1)));
		end

		wait_idle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== gaussian_blur_5x5_clamped.f =====
rtl/gbc_pkg.sv
rtl/gbc_line_bank.sv
rtl/gbc_cell.sv
rtl/gaussian_blur_5x5_clamped.sv
rtl/gbc_checker.sv
bench/tb_gaussian_blur_5x5_clamped.sv
